// ----- design/text_console_character_engine_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Text console character engine - assertion macros
// Shared property wrappers, clocked on clk with rst_n as the disable.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHARACTER_ENGINE_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CHARACTER_ENGINE_UNIT_MACROS_SVH

// same-cycle implication
`define TCCE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// tcce_pkg
// Types and constants shared by the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int INDEX_W = 11;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = 16;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_SET   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic [APB_AW-3:0] REG_TEXT_ATTRIBUTE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_BLANK,
        ST_CP_RD,
        ST_CP_WR,
        ST_BOTTOM,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        RAM_NONE,
        RAM_EXEC,
        RAM_BLANK,
        RAM_COPY_RD,
        RAM_COPY_WR
    } ram_op_t;

    typedef enum logic [1:0] {
        SW_LINE,
        SW_ALL,
        SW_COPY,
        SW_BOTTOM
    } sweep_sel_t;

    typedef struct packed {
        logic       load_in;
        logic       load_out;
        logic       cur_update;
        ram_op_t    ram_op;
        logic       sweep_load;
        sweep_sel_t sweep_sel;
        logic       sweep_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic clear;
        logic line_feed;
        logic scroll;
        logic scroll_pend;
        logic sweep_last;
    } dp_status_t;

endpackage

// ----- design/text_console_character_engine_unit.sv -----
// ----------------------------------------------------------------------------
// text_console_character_engine_unit
// Text console: COLUMNS x ROWS character cells with cursor, scroll and clear.
// ----------------------------------------------------------------------------
// One item is processed at a time and each item returns one transfer on the
// output channel. A line feed blanks its line from the cursor column to the
// end (COLUMNS minus the cursor column cells). A scroll copies each of the
// COLUMNS*(ROWS-1) cells below the top row up one row and then blanks the
// bottom line; clear screen blanks all COLUMNS*ROWS cells. The screen RAM has
// a single write port, which takes one cell per cycle, and a registered read,
// so each copied cell takes a read state and a write state. The screen RAM is
// not cleared after reset: a cell that was never written reads back as an
// unknown value. The text_attribute register (offset 0x0, reset 0x07) is used
// for every printed or blanked cell; a copied cell keeps its own attribute.
// ----------------------------------------------------------------------------
module text_console_character_engine_unit #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcce_pkg::APB_AW-1:0]      paddr,
    input  logic [tcce_pkg::APB_DW-1:0]      pwdata,
    output logic [tcce_pkg::APB_DW-1:0]      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tcce_pkg::OP_W-1:0]        operation,
    input  logic [tcce_pkg::CHAR_W-1:0]      char_code,
    input  logic [tcce_pkg::COL_W-1:0]       column,
    input  logic [tcce_pkg::ROW_W-1:0]       row,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tcce_pkg::COL_W-1:0]       cursor_column,
    output logic [tcce_pkg::ROW_W-1:0]       cursor_row,
    output logic [tcce_pkg::INDEX_W-1:0]     cursor_index,
    output logic [tcce_pkg::CHAR_W-1:0]      cell_char,
    output logic [tcce_pkg::ATTR_W-1:0]      cell_attr
);

    import tcce_pkg::*;

    logic [ATTR_W-1:0] text_attribute_reg;
    logic              attr_sel;
    dp_cmd_t           cmd;
    dp_status_t        status;

    assign pready   = 1'b1;
    assign attr_sel = (paddr[APB_AW-1:2] == REG_TEXT_ATTRIBUTE);
    assign prdata   = attr_sel ? APB_DW'(text_attribute_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attribute_reg <= ATTR_RESET;
        end
        else if (psel && penable && pwrite && pready && attr_sel)
        begin
            text_attribute_reg <= pwdata[ATTR_W-1:0];
        end
    end

    tcce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tcce_datapath #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .attr          (text_attribute_reg),
        .operation     (operation),
        .char_code     (char_code),
        .column        (column),
        .row           (row),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .cursor_index  (cursor_index),
        .cell_char     (cell_char),
        .cell_attr     (cell_attr)
    );

endmodule

// ----- design/tcce_ram.sv -----
// ----------------------------------------------------------------------------
// tcce_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/tcce_datapath.sv -----
// ----------------------------------------------------------------------------
// tcce_datapath
// Cursor, item and result registers, screen RAM and sweep address counter.
// ----------------------------------------------------------------------------
module tcce_datapath #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcce_pkg::dp_cmd_t                cmd,
    output tcce_pkg::dp_status_t             status,
    input  logic [tcce_pkg::ATTR_W-1:0]      attr,
    input  logic [tcce_pkg::OP_W-1:0]        operation,
    input  logic [tcce_pkg::CHAR_W-1:0]      char_code,
    input  logic [tcce_pkg::COL_W-1:0]       column,
    input  logic [tcce_pkg::ROW_W-1:0]       row,
    output logic [tcce_pkg::COL_W-1:0]       cursor_column,
    output logic [tcce_pkg::ROW_W-1:0]       cursor_row,
    output logic [tcce_pkg::INDEX_W-1:0]     cursor_index,
    output logic [tcce_pkg::CHAR_W-1:0]      cell_char,
    output logic [tcce_pkg::ATTR_W-1:0]      cell_attr
);

    import tcce_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int TW    = CW + 5;

    function automatic int next_tab_stop(input int col_val);
        int stop;
        stop = TAB_WIDTH;
        for (int k = 0; k < 128; k++)
        begin
            if (stop <= col_val)
            begin
                stop = stop + TAB_WIDTH;
            end
        end
        return stop;
    endfunction

    logic [OP_W-1:0]    op_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [COL_W-1:0]   col_in_reg;
    logic [ROW_W-1:0]   row_in_reg;
    logic [CW-1:0]      cur_col_reg;
    logic [RW-1:0]      cur_row_reg;
    logic [CW-1:0]      cur_col_next;
    logic [RW-1:0]      cur_row_next;
    logic               scroll_pend_reg;
    logic [AW-1:0]      sweep_addr_reg;
    logic [AW-1:0]      sweep_end_reg;
    logic [AW-1:0]      sweep_addr_next;
    logic [AW-1:0]      sweep_end_next;

    logic [COL_W-1:0]   cursor_column_reg;
    logic [ROW_W-1:0]   cursor_row_reg;
    logic [INDEX_W-1:0] cursor_index_reg;
    logic [CHAR_W-1:0]  cell_char_reg;
    logic [ATTR_W-1:0]  cell_attr_reg;

    logic [TW-1:0]      tab_stop [COLUMNS];
    logic [TW-1:0]      tab_next;
    logic [CW:0]        col_inc;
    logic [RW:0]        row_inc;
    logic               is_print;
    logic               is_bs;
    logic               is_lf;
    logic               adv_line;
    logic               exec_scroll;
    logic               read_ok;
    logic [CW-1:0]      ex_col;
    logic [RW-1:0]      ex_row;
    logic [AW-1:0]      ex_base;
    logic [AW-1:0]      ex_addr;
    logic [AW-1:0]      line_end;
    logic [AW-1:0]      cur_lin;

    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [CELL_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [CELL_W-1:0]  ram_rd_data;

    genvar gc;
    generate
        for (gc = 0; gc < COLUMNS; gc++)
        begin : g_tab
            assign tab_stop[gc] = TW'(next_tab_stop(gc));
        end
    endgenerate

    assign tab_next = tab_stop[cur_col_reg];
    assign col_inc  = {1'b0, cur_col_reg} + (CW+1)'(1);
    assign row_inc  = {1'b0, cur_row_reg} + (RW+1)'(1);
    assign read_ok  = (32'(col_in_reg) < 32'(COLUMNS)) && (32'(row_in_reg) < 32'(ROWS));

    // item decode and cursor after the item
    always_comb
    begin
        is_print     = 1'b0;
        is_bs        = 1'b0;
        is_lf        = 1'b0;
        adv_line     = 1'b0;
        exec_scroll  = 1'b0;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        case (op_reg)
            OP_PUT:
            begin
                case (char_reg)
                    CH_BS:
                    begin
                        is_bs = 1'b1;
                        if (cur_col_reg != '0)
                        begin
                            cur_col_next = cur_col_reg - CW'(1);
                        end
                        else if (cur_row_reg != '0)
                        begin
                            cur_row_next = cur_row_reg - RW'(1);
                            cur_col_next = CW'(COLUMNS - 1);
                        end
                    end
                    CH_TAB:
                    begin
                        if (tab_next >= TW'(COLUMNS))
                        begin
                            adv_line = 1'b1;
                        end
                        else
                        begin
                            cur_col_next = tab_next[CW-1:0];
                        end
                    end
                    CH_CR:
                    begin
                        cur_col_next = '0;
                    end
                    CH_LF:
                    begin
                        is_lf    = 1'b1;
                        adv_line = 1'b1;
                    end
                    default:
                    begin
                        if (char_reg >= CH_SPACE)
                        begin
                            is_print = 1'b1;
                            if (col_inc >= (CW+1)'(COLUMNS))
                            begin
                                adv_line = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = col_inc[CW-1:0];
                            end
                        end
                    end
                endcase
            end
            OP_SET:
            begin
                cur_col_next = (32'(col_in_reg) < 32'(COLUMNS)) ? CW'(col_in_reg)
                                                                : CW'(COLUMNS - 1);
                cur_row_next = (32'(row_in_reg) < 32'(ROWS)) ? RW'(row_in_reg)
                                                             : RW'(ROWS - 1);
            end
            OP_CLEAR:
            begin
                cur_col_next = '0;
                cur_row_next = '0;
            end
            default:
            begin
                cur_col_next = cur_col_reg;
            end
        endcase
        if (adv_line)
        begin
            cur_col_next = '0;
            if (row_inc >= (RW+1)'(ROWS))
            begin
                exec_scroll  = 1'b1;
                cur_row_next = RW'(ROWS - 1);
            end
            else
            begin
                cur_row_next = row_inc[RW-1:0];
            end
        end
    end

    // cell address of the item: backspace hits the new cursor, read the given cell
    always_comb
    begin
        ex_col = cur_col_reg;
        ex_row = cur_row_reg;
        if (is_bs)
        begin
            ex_col = cur_col_next;
            ex_row = cur_row_next;
        end
        else if (op_reg == OP_READ)
        begin
            ex_col = CW'(col_in_reg);
            ex_row = RW'(row_in_reg);
        end
    end

    assign ex_base  = AW'(AW'(ex_row) * AW'(COLUMNS));
    assign ex_addr  = ex_base + AW'(ex_col);
    assign line_end = ex_base + AW'(COLUMNS - 1);
    assign cur_lin  = AW'(AW'(cur_row_reg) * AW'(COLUMNS)) + AW'(cur_col_reg);

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = sweep_addr_reg;
        ram_wr_data = {attr, CH_SPACE};
        ram_rd_en   = 1'b0;
        ram_rd_addr = ex_addr;
        unique case (cmd.ram_op)
            RAM_EXEC:
            begin
                ram_wr_en   = is_print || is_bs;
                ram_wr_addr = ex_addr;
                ram_wr_data = {attr, (is_print ? char_reg : CH_SPACE)};
                ram_rd_en   = (op_reg == OP_READ) && read_ok;
            end
            RAM_BLANK:
            begin
                ram_wr_en = 1'b1;
            end
            RAM_COPY_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = sweep_addr_reg + AW'(COLUMNS);
            end
            RAM_COPY_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = ram_rd_data;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        if (cmd.sweep_load)
        begin
            unique case (cmd.sweep_sel)
                SW_LINE:
                begin
                    sweep_addr_next = ex_addr;
                    sweep_end_next  = line_end;
                end
                SW_ALL:
                begin
                    sweep_addr_next = '0;
                    sweep_end_next  = AW'(CELLS - 1);
                end
                SW_COPY:
                begin
                    sweep_addr_next = '0;
                    sweep_end_next  = AW'(CELLS - COLUMNS - 1);
                end
                SW_BOTTOM:
                begin
                    sweep_addr_next = AW'(CELLS - COLUMNS);
                    sweep_end_next  = AW'(CELLS - 1);
                end
                default:
                begin
                    sweep_addr_next = '0;
                end
            endcase
        end
        else if (cmd.sweep_inc)
        begin
            sweep_addr_next = sweep_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            scroll_pend_reg <= 1'b0;
            sweep_addr_reg  <= '0;
            sweep_end_reg   <= '0;
        end
        else
        begin
            if (cmd.cur_update)
            begin
                cur_col_reg     <= cur_col_next;
                cur_row_reg     <= cur_row_next;
                scroll_pend_reg <= exec_scroll;
            end
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg     <= operation;
            char_reg   <= char_code;
            col_in_reg <= column;
            row_in_reg <= row;
        end
        if (cmd.load_out)
        begin
            cursor_column_reg <= COL_W'(cur_col_reg);
            cursor_row_reg    <= ROW_W'(cur_row_reg);
            cursor_index_reg  <= INDEX_W'(cur_lin);
            if ((op_reg == OP_READ) && read_ok)
            begin
                cell_char_reg <= ram_rd_data[CHAR_W-1:0];
                cell_attr_reg <= ram_rd_data[CELL_W-1:CHAR_W];
            end
            else
            begin
                cell_char_reg <= '0;
                cell_attr_reg <= '0;
            end
        end
    end

    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign status.clear       = (op_reg == OP_CLEAR);
    assign status.line_feed   = is_lf;
    assign status.scroll      = exec_scroll;
    assign status.scroll_pend = scroll_pend_reg;
    assign status.sweep_last  = (sweep_addr_reg == sweep_end_reg);

    assign cursor_column = cursor_column_reg;
    assign cursor_row    = cursor_row_reg;
    assign cursor_index  = cursor_index_reg;
    assign cell_char     = cell_char_reg;
    assign cell_attr     = cell_attr_reg;

endmodule

// ----- design/tcce_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcce_ctrl
// Sequencer: item execution, line/screen blanking, scroll copy, result handoff.
// ----------------------------------------------------------------------------
`include "text_console_character_engine_unit_macros.svh"

module tcce_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  tcce_pkg::dp_status_t status,
    output tcce_pkg::dp_cmd_t    cmd
);

    import tcce_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        cmd            = '0;
        cmd.ram_op     = RAM_NONE;
        cmd.sweep_sel  = SW_LINE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.cur_update = 1'b1;
                cmd.ram_op     = RAM_EXEC;
                if (status.clear)
                begin
                    cmd.sweep_load = 1'b1;
                    cmd.sweep_sel  = SW_ALL;
                    state_next     = ST_BLANK;
                end
                else if (status.line_feed)
                begin
                    cmd.sweep_load = 1'b1;
                    cmd.sweep_sel  = SW_LINE;
                    state_next     = ST_BLANK;
                end
                else if (status.scroll)
                begin
                    cmd.sweep_load = 1'b1;
                    cmd.sweep_sel  = SW_COPY;
                    state_next     = ST_CP_RD;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_BLANK:
            begin
                cmd.ram_op    = RAM_BLANK;
                cmd.sweep_inc = 1'b1;
                if (status.sweep_last)
                begin
                    if (status.scroll_pend)
                    begin
                        cmd.sweep_load = 1'b1;
                        cmd.sweep_sel  = SW_COPY;
                        state_next     = ST_CP_RD;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_CP_RD:
            begin
                cmd.ram_op = RAM_COPY_RD;
                state_next = ST_CP_WR;
            end
            ST_CP_WR:
            begin
                cmd.ram_op    = RAM_COPY_WR;
                cmd.sweep_inc = 1'b1;
                if (status.sweep_last)
                begin
                    cmd.sweep_load = 1'b1;
                    cmd.sweep_sel  = SW_BOTTOM;
                    state_next     = ST_BOTTOM;
                end
                else
                begin
                    state_next = ST_CP_RD;
                end
            end
            ST_BOTTOM:
            begin
                cmd.ram_op    = RAM_BLANK;
                cmd.sweep_inc = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    in_stall       = 1'b0;
                    if (in_valid)
                    begin
                        cmd.load_in = 1'b1;
                        state_next  = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `TCCE_ASSERT_SAME(a_accept_state, !in_stall, state_reg == ST_IDLE || state_reg == ST_FINISH, "item taken while busy")
    `TCCE_ASSERT_SAME(a_load_free, cmd.load_out, !out_valid_reg || !out_stall, "result overwritten")
    `TCCE_ASSERT_NEXT(a_result_shown, cmd.load_out, out_valid_reg, "result not presented")
    `TCCE_ASSERT_NEXT(a_copy_pair, state_reg == ST_CP_RD, state_reg == ST_CP_WR, "copy read without write")
    `TCCE_ASSERT_NEXT(a_short_item, state_reg == ST_EXEC && !status.clear && !status.line_feed && !status.scroll, state_reg == ST_FINISH, "short item did not finish")

endmodule
